// ===== design/pdh_pkg.sv =====
`timescale 1ns / 1ps
package pdh_pkg;
  localparam int NumHist  = 8;
  localparam int MaxBins  = 256;
  localparam int NumTypes = 16;
  localparam int HistAw   = $clog2(NumHist * MaxBins);
  localparam int BinAw    = $clog2(MaxBins);
  localparam int HselW    = $clog2(NumHist);
  localparam int TypeW    = $clog2(NumTypes);
  localparam int MapAw    = 2 * TypeW;

  localparam logic [1:0] CmdTally = 2'd0;
  localparam logic [1:0] CmdMap   = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  localparam logic [1:0] RegBinCount = 2'd0;
  localparam logic [1:0] RegInvWidth = 2'd1;
  localparam logic [1:0] RegSkipMask = 2'd2;
  localparam logic [1:0] RegNewton   = 2'd3;

  typedef struct packed {
    logic        start;
    logic [47:0] rsq;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] root;
  } sqrt_rsp_t;
endpackage

// ===== design/pdh_sqrt.sv =====
`timescale 1ns / 1ps
// Restoring square root, one result bit per cycle.
module pdh_sqrt import pdh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);
  logic [47:0] rad_q, rad_d;
  logic [25:0] rem_q, rem_d;
  logic [23:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [27:0] part;
  logic [27:0] trial;

  always_comb begin
    rad_d = rad_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    // The partial remainder takes in the next two radicand bits on each step.
    part  = {rem_q, rad_q[47:46]};
    trial = {2'b00, root_q, 2'b01};
    if (req_i.start) begin
      rad_d = req_i.rsq; rem_d = '0; root_d = '0; cnt_d = 5'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[45:0], 2'b00};
      if (part >= trial) begin
        rem_d  = 26'(part - trial);
        root_d = {root_q[22:0], 1'b1};
      end else begin
        rem_d  = part[25:0];
        root_d = {root_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
endmodule

// ===== design/pair_distance_histogram_top.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Signals
// input   | in        | in_valid_i, in_stall_o, command_i .. bin_select_i
// result  | out       | out_valid_o, out_stall_i, read_count_o .. beyond_range_o
// config  | in        | cfg_we_i, cfg_index_i, cfg_wdata_i
// After reset a clearing pass zeroes all 2048 histogram entries; no request
// is taken meanwhile. The pair map valid bits clear with the reset.
// A tally reads the pair map twice, squares and sums the three deltas, takes
// the square root, scales it to a bin, then reads and writes each of the 16
// histogram slots in turn. A skipped pair stops during the squaring step.
// A bin beyond range skips the slot updates. A clear zeroes the whole histogram
// memory. The result is held until taken; the next request can be accepted in the cycle after it has left.
module pair_distance_histogram_top import pdh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [23:0] delta_x_i,
  input  logic signed [23:0] delta_y_i,
  input  logic signed [23:0] delta_z_i,
  input  logic [3:0]         type_i_i,
  input  logic [3:0]         type_j_i,
  input  logic [1:0]         bond_class_i,
  input  logic               both_in_group_i,
  input  logic               neighbor_local_i,
  input  logic [7:0]         map_bits_i,
  input  logic [2:0]         hist_select_i,
  input  logic [7:0]         bin_select_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        read_count_o,
  output logic [4:0]         increments_o,
  output logic [7:0]         bin_hit_o,
  output logic               beyond_range_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i
);
  localparam logic [3:0] SInit = 4'd0, SIdle = 4'd1, SMap0 = 4'd2, SMap1 = 4'd3,
    SMul = 4'd4, SSqrt = 4'd5, SBin = 4'd6, SRmwRd = 4'd7, SRmwWr = 4'd8,
    SRead = 4'd9, SClear = 4'd10, SOut = 4'd11, SBin2 = 4'd12, SRead2 = 4'd13;

  logic [3:0] st_q, st_d;
  logic [8:0]  bin_count_q;
  logic [23:0] inv_w_q;
  logic [3:0]  skip_q;
  logic        newton_q;

  logic [31:0] hist_mem [NumHist*MaxBins];
  logic [7:0]  map_mem [NumTypes*NumTypes];
  logic [NumTypes*NumTypes-1:0] map_vld_q;

  logic [HistAw-1:0] clr_q;
  logic signed [23:0] dx_q, dy_q, dz_q;
  logic [3:0]  ti_q, tj_q;
  logic        loc_q, grp_q;
  logic [1:0]  cls_q;
  logic [2:0]  hsel_q;
  logic [7:0]  bsel_q;

  logic [7:0]  fwd_q, rev_q, map_rd_q;
  logic [47:0] acc_q;
  logic [1:0]  mcnt_q;
  logic [47:0] prod_q;
  logic [4:0]  slot_q;
  logic [7:0]  bin_q;
  logic [4:0]  inc_q;
  logic [31:0] rd_q;
  logic [HistAw-1:0] ha_q;

  logic [31:0] r_count_q;
  logic [4:0]  r_inc_q;
  logic [7:0]  r_bin_q;
  logic        r_br_q;

  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;
  pdh_sqrt u_sqrt (.clk_i, .rst_ni, .req_i(sq_req), .rsp_o(sq_rsp));

  logic        accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != SIdle);
  assign out_valid_o = (st_q == SOut);

  // Multiplier operand for the shared squaring unit.
  logic signed [23:0] sqop;
  always_comb begin
    case (mcnt_q)
      2'd0:    sqop = dx_q;
      2'd1:    sqop = dy_q;
      default: sqop = dz_q;
    endcase
  end
  logic [47:0] sq;
  assign sq = {{24{sqop[23]}}, sqop} * {{24{sqop[23]}}, sqop};

  logic [47:0] binprod;
  assign binprod = {24'd0, sq_rsp.root} * {24'd0, inv_w_q};
  logic [19:0] bin_full;
  assign bin_full = prod_q[47:28];
  logic [8:0]  nb;
  assign nb = (bin_count_q > 9'(MaxBins)) ? 9'(MaxBins) : bin_count_q;

  logic [7:0]  set_cur;
  logic        hit;
  logic [2:0]  hidx;
  assign hidx = slot_q[2:0];
  assign set_cur = slot_q[3] ? rev_q : fwd_q;
  assign hit = set_cur[hidx];

  logic [7:0] map_word;
  assign map_word = map_vld_q[{ti_q, tj_q}] ? map_rd_q : 8'd0;

  // The reverse map counts here before the direction filter is applied.
  logic skip;
  assign skip = skip_q[cls_q] || !grp_q ||
                (fwd_q == 8'd0 && (!map_vld_q[{tj_q, ti_q}] || map_rd_q == 8'd0));

  always_comb begin
    st_d = st_q;
    sq_req.start = 1'b0;
    sq_req.rsq = acc_q;
    unique case (st_q)
      SInit:  if (clr_q == HistAw'(NumHist*MaxBins-1)) st_d = SIdle;
      SIdle:  if (accept) begin
        unique case (command_i)
          CmdTally: st_d = SMap0;
          CmdMap:   st_d = SOut;
          CmdRead:  st_d = SRead;
          default:  st_d = SClear;
        endcase
      end
      SMap0:  st_d = SMap1;
      SMap1:  st_d = SMul;
      SMul:   if (mcnt_q == 2'd1 && skip) begin
        st_d = SOut;
      end else if (mcnt_q == 2'd3) begin
        st_d = SSqrt; sq_req.start = 1'b1;
      end
      SSqrt:  if (sq_rsp.done) st_d = SBin;
      SBin:   st_d = SBin2;
      SBin2:  st_d = ({11'd0, bin_full} >= {22'd0, nb}) ? SOut : SRmwRd;
      SRmwRd: st_d = SRmwWr;
      SRmwWr: st_d = (slot_q == 5'd15) ? SOut : SRmwRd;
      SRead:  st_d = SRead2;
      SRead2: st_d = SOut;
      SClear: if (clr_q == HistAw'(NumHist*MaxBins-1)) st_d = SOut;
      SOut:   if (!out_stall_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SInit; clr_q <= '0; map_vld_q <= '0;
      bin_count_q <= 9'd256; inv_w_q <= 24'd65536; skip_q <= 4'd1; newton_q <= 1'b1;
    end else begin
      st_q <= st_d;
      if (st_q == SInit || st_q == SClear) clr_q <= clr_q + 1'b1;
      if (st_q == SIdle && accept && command_i == CmdMap) map_vld_q[{type_i_i, type_j_i}] <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegBinCount: bin_count_q <= cfg_wdata_i[8:0];
          RegInvWidth: inv_w_q <= cfg_wdata_i;
          RegSkipMask: skip_q <= cfg_wdata_i[3:0];
          default:     newton_q <= cfg_wdata_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && accept) begin
      dx_q <= delta_x_i; dy_q <= delta_y_i; dz_q <= delta_z_i;
      ti_q <= type_i_i; tj_q <= type_j_i; cls_q <= bond_class_i;
      grp_q <= both_in_group_i; loc_q <= neighbor_local_i;
      hsel_q <= hist_select_i; bsel_q <= bin_select_i;
      r_count_q <= '0; r_inc_q <= '0; r_bin_q <= '0; r_br_q <= 1'b0;
      acc_q <= '0; mcnt_q <= '0; slot_q <= '0; inc_q <= '0;
      if (command_i == CmdMap) map_mem[{type_i_i, type_j_i}] <= map_bits_i;
    end
    if (st_q == SInit || st_q == SClear) hist_mem[clr_q] <= '0;
    map_rd_q <= map_mem[(st_q == SMap0) ? {ti_q, tj_q} : {tj_q, ti_q}];
    if (st_q == SMap0) begin
      fwd_q <= 8'd0;
    end
    if (st_q == SMap1) begin
      fwd_q <= map_word;
    end
    if (st_q == SMul) begin
      if (mcnt_q == 2'd1) begin
        rev_q <= (map_vld_q[{tj_q, ti_q}] ? map_rd_q : 8'd0)
                 & ((newton_q || loc_q) ? 8'hFF : 8'h00);
      end
      if (mcnt_q != 2'd3) acc_q <= acc_q + sq;
      mcnt_q <= mcnt_q + 2'd1;
    end
    if (st_q == SBin) prod_q <= binprod;
    if (st_q == SBin2) begin
      r_bin_q <= (bin_full > 20'd255) ? 8'd255 : bin_full[7:0];
      bin_q <= bin_full[7:0];
      if ({11'd0, bin_full} >= {22'd0, nb}) r_br_q <= 1'b1;
    end
    if (st_q == SRmwRd) begin
      ha_q <= {hidx, bin_q};
      rd_q <= hist_mem[{hidx, bin_q}];
    end
    if (st_q == SRmwWr) begin
      if (hit) begin
        hist_mem[ha_q] <= (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;
        inc_q <= inc_q + 5'd1;
      end
      slot_q <= slot_q + 5'd1;
      if (slot_q == 5'd15) r_inc_q <= inc_q + {4'd0, hit};
    end
    if (st_q == SRead) rd_q <= hist_mem[{hsel_q, bsel_q}];
    if (st_q == SRead2) r_count_q <= rd_q;
  end

  assign read_count_o   = r_count_q;
  assign increments_o   = r_inc_q;
  assign bin_hit_o      = r_bin_q;
  assign beyond_range_o = r_br_q;
endmodule

// ===== design/pdh_checker.sv =====
`timescale 1ns / 1ps
module pdh_checker (
  input logic clk_i, rst_ni, in_stall_o, out_valid_o, out_stall_i,
  input logic [4:0] increments_o,
  input logic beyond_range_o
);
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open with result pending");
  a_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beyond_range_o |-> increments_o == 5'd0) else $error("inc beyond");
  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> increments_o <= 5'd16) else $error("inc too big");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
endmodule

bind pair_distance_histogram_top pdh_checker u_chk (.*);
